@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/rlm_pkg.sv @@
`default_nettype none

package rlm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CHAN_W    = 3;
    localparam int LEVEL_W   = 16;

    // Square of a Q1.15 magnitude is at most 2^30.
    localparam int SQ_W      = 2 * (SAMPLE_W - 1) + 1;

    // Shared multiplier.
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;

    // log2 mantissa in Q1.30 and fraction bits of the Q.24 result.
    localparam int Y_W       = 31;
    localparam int FRAC_BITS = 24;
    localparam int ITER_W    = 5;

    localparam int MAG_W     = 15;
    localparam logic [MAG_W-1:0] FLOOR_MAG = MAG_W'(25600);
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -16'sd25600;

    // 5^10: the floor test is S * 5^10 < N * 2^20.
    localparam logic [MUL_W-1:0] FIVE_POW_10    = 32'd9765625;
    localparam int               FLOOR_SHIFT    = 20;
    // 256 * 10 * log10(2) in Q.20.
    localparam logic [MUL_W-1:0] DB_PER_OCT_Q20 = 32'd808071242;
    // Full scale 2^30 as a Q.24 log2.
    localparam logic [MUL_W-1:0] FULL_SCALE_Q24 = 32'd503316480;
    localparam logic [PROD_W-1:0] ROUND_Q44     = 64'h0000_0800_0000_0000;
    localparam int               MAG_SHIFT      = 44;

    typedef struct packed {
        logic start;
        logic overflow;
    } chunk_ctl_t;

endpackage

`default_nettype wire

@@ rtl/rlm_ifs.sv @@
`default_nettype none

interface rlm_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rlm_pkg::SAMPLE_W-1:0]   sample;
    logic [rlm_pkg::CHAN_W-1:0]            channel;
    logic                                  end_of_chunk;

    modport source (output valid, sample, channel, end_of_chunk, input ready);
    modport sink   (input valid, sample, channel, end_of_chunk, output ready);
endinterface

interface rlm_level_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rlm_pkg::LEVEL_W-1:0]    level_db;
    logic                                  overflow;

    modport source (output valid, level_db, overflow, input ready);
    modport sink   (input valid, level_db, overflow, output ready);
endinterface

interface rlm_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [rlm_pkg::CHAN_W-1:0]            channel_select;

    modport source (output valid, channel_select, input ready);
    modport sink   (input valid, channel_select, output ready);
endinterface

`default_nettype wire

@@ rtl/rms_level_meter_db.sv @@
`default_nettype none

// RMS level meter. Samples of the selected channel are squared and summed, one sample
// transaction per cycle while the channel is ready, until a transaction with
// end_of_chunk set; the block then reports 10*log10 of the mean square relative to
// full scale in Q7.8 dB, floored at -100 dB, with the chunk's overflow flag, and
// starts a new chunk. After the end-of-chunk transaction the sample channel is not
// ready while the chunk is handed off and during the level computation, which runs
// on one shared 32x32 multiplier: the floor test when the sum is below the count,
// then for each of log2(sum) and log2(count) the one-bit normalizing shifts and 24
// squarings, then scaling and rounding. A finished level waits in an output register
// while samples of the next chunk are accepted; a second level computation completes
// only once that register is free.
module rms_level_meter_db
#(
    parameter int CHANNELS = 8,
    parameter int MAX_FRAMES = 1024
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    rlm_sample_if.sink   samples,
    rlm_level_if.source  levels,
    rlm_cfg_if.sink      cfg
);

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W = CNT_W + rlm_pkg::SQ_W - 1;

    logic [SUM_W-1:0]     chunk_sum;
    logic [CNT_W-1:0]     chunk_count;
    rlm_pkg::chunk_ctl_t  chunk_ctl;
    logic                 level_busy;

    rlm_accum
    #(
        .CHANNELS   (CHANNELS),
        .MAX_FRAMES (MAX_FRAMES),
        .CNT_W      (CNT_W),
        .SUM_W      (SUM_W)
    )
    u_accum
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples),
        .cfg         (cfg),
        .level_busy  (level_busy),
        .chunk_sum   (chunk_sum),
        .chunk_count (chunk_count),
        .chunk_ctl   (chunk_ctl)
    );

    rlm_level
    #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    )
    u_level
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .chunk_sum   (chunk_sum),
        .chunk_count (chunk_count),
        .chunk_ctl   (chunk_ctl),
        .busy        (level_busy),
        .levels      (levels)
    );

    `ASSERT_IMPLIES(level_in_range, clk, rst_n, levels.valid, (levels.level_db <= 16'sd0) && (levels.level_db >= rlm_pkg::LEVEL_MIN))
    `ASSERT_NEXT(eoc_starts_level, clk, rst_n, samples.valid && samples.ready && samples.end_of_chunk, chunk_ctl.start && !samples.ready)
    `ASSERT_IMPLIES(start_when_idle, clk, rst_n, chunk_ctl.start, !level_busy)

endmodule

`default_nettype wire

@@ rtl/rlm_mul.sv @@
`default_nettype none

module rlm_mul
(
    input  wire logic                        clk,
    input  wire logic [rlm_pkg::MUL_W-1:0]   a,
    input  wire logic [rlm_pkg::MUL_W-1:0]   b,
    output logic      [rlm_pkg::PROD_W-1:0]  p
);

    logic [rlm_pkg::PROD_W-1:0] p_reg;
    logic [rlm_pkg::PROD_W-1:0] p_next;

    assign p_next = rlm_pkg::PROD_W'(a) * rlm_pkg::PROD_W'(b);
    assign p      = p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

endmodule

`default_nettype wire

@@ rtl/rlm_accum.sv @@
`default_nettype none

module rlm_accum
#(
    parameter int CHANNELS = 8,
    parameter int MAX_FRAMES = 1024,
    parameter int CNT_W = 11,
    parameter int SUM_W = 41
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    rlm_sample_if.sink             samples,
    rlm_cfg_if.sink                cfg,
    input  wire logic              level_busy,
    output logic [SUM_W-1:0]       chunk_sum,
    output logic [CNT_W-1:0]       chunk_count,
    output rlm_pkg::chunk_ctl_t    chunk_ctl
);

    localparam int CH_CMP_W = 7;

    logic [rlm_pkg::CHAN_W-1:0]    chsel_reg;
    logic                          flush_reg, flush_next;
    logic                          sq_vld_reg, sq_vld_next;
    logic [rlm_pkg::SQ_W-1:0]      sq_reg, sq_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          ovf_reg, ovf_next;

    logic                          accept;
    logic                          take;
    logic                          room;
    logic [rlm_pkg::SAMPLE_W-1:0]  sample_u;
    logic [rlm_pkg::SAMPLE_W-1:0]  mag;
    logic [2*rlm_pkg::SAMPLE_W-1:0] sq_full;
    logic [SUM_W-1:0]              sum_add;

    assign cfg.ready     = 1'b1;
    assign samples.ready = !flush_reg && !level_busy;
    assign accept        = samples.valid && samples.ready;

    assign take = accept && (samples.channel == chsel_reg) &&
                  ({{(CH_CMP_W - rlm_pkg::CHAN_W){1'b0}}, samples.channel} <
                   CH_CMP_W'(CHANNELS));
    assign room = count_reg < CNT_W'(MAX_FRAMES);

    assign sample_u = samples.sample;
    assign mag      = sample_u[rlm_pkg::SAMPLE_W-1] ? (~sample_u + 1'b1) : sample_u;
    assign sq_full  = {{rlm_pkg::SAMPLE_W{1'b0}}, mag} * {{rlm_pkg::SAMPLE_W{1'b0}}, mag};
    assign sq_next  = sq_full[rlm_pkg::SQ_W-1:0];

    // The square of the previous sample is added in the cycle after it was taken.
    assign sum_add = sum_reg +
                     (sq_vld_reg ? {{(SUM_W - rlm_pkg::SQ_W){1'b0}}, sq_reg} : '0);

    assign chunk_sum          = sum_add;
    assign chunk_count        = count_reg;
    assign chunk_ctl.start    = flush_reg;
    assign chunk_ctl.overflow = ovf_reg;

    always_comb
    begin
        flush_next  = accept && samples.end_of_chunk;
        sq_vld_next = take && room;
        sum_next    = sum_add;
        count_next  = count_reg + CNT_W'(take && room);
        ovf_next    = ovf_reg || (take && !room);
        if (flush_reg)
        begin
            flush_next  = 1'b0;
            sq_vld_next = 1'b0;
            sum_next    = '0;
            count_next  = '0;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chsel_reg  <= '0;
            flush_reg  <= 1'b0;
            sq_vld_reg <= 1'b0;
            sum_reg    <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                chsel_reg <= cfg.channel_select;
            end
            flush_reg  <= flush_next;
            sq_vld_reg <= sq_vld_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

endmodule

`default_nettype wire

@@ rtl/rlm_level.sv @@
`default_nettype none

module rlm_level
#(
    parameter int CNT_W = 11,
    parameter int SUM_W = 41
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [SUM_W-1:0]      chunk_sum,
    input  wire logic [CNT_W-1:0]      chunk_count,
    input  rlm_pkg::chunk_ctl_t        chunk_ctl,
    output logic                       busy,
    rlm_level_if.source                levels
);

    localparam int NORM_W = (SUM_W > rlm_pkg::Y_W) ? SUM_W : rlm_pkg::Y_W;
    localparam int E_W    = $clog2(NORM_W);
    localparam int L_W    = E_W + rlm_pkg::FRAC_BITS;
    localparam int D_W    = rlm_pkg::MUL_W + 1;
    localparam int T_W    = rlm_pkg::Y_W + 1;
    localparam int M_W    = rlm_pkg::PROD_W - rlm_pkg::MAG_SHIFT;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FLOOR_MUL,
        S_FLOOR_CHK,
        S_NORM,
        S_SQ_MUL,
        S_SQ_CHK,
        S_DIFF,
        S_MAG_MUL,
        S_MAG_RND,
        S_DONE
    } state_t;

    state_t                             state_reg, state_next;
    logic                               pass_reg, pass_next;
    logic [rlm_pkg::ITER_W-1:0]         iter_reg, iter_next;
    logic                               out_vld_reg, out_vld_next;

    // Only a sum below the count reaches the floor test, so the count's width is enough.
    logic [CNT_W-1:0]                   s_reg, s_next;
    logic [CNT_W-1:0]                   n_reg, n_next;
    logic                               ovf_reg, ovf_next;
    logic [NORM_W-1:0]                  x_reg, x_next;
    logic [E_W-1:0]                     e_reg, e_next;
    logic [rlm_pkg::Y_W-1:0]            y_reg, y_next;
    logic [rlm_pkg::FRAC_BITS-1:0]      frac_reg, frac_next;
    logic [L_W-1:0]                     ls_reg, ls_next;
    logic [rlm_pkg::MUL_W-1:0]          d_reg, d_next;
    logic [rlm_pkg::MAG_W-1:0]          mag_reg, mag_next;
    logic signed [rlm_pkg::LEVEL_W-1:0] out_level_reg, out_level_next;
    logic                               out_ovf_reg, out_ovf_next;

    logic [rlm_pkg::MUL_W-1:0]          mul_a;
    logic [rlm_pkg::MUL_W-1:0]          mul_b;
    logic [rlm_pkg::PROD_W-1:0]         prod;
    logic [T_W-1:0]                     sq_t;
    logic [rlm_pkg::FRAC_BITS-1:0]      frac_step;
    logic [rlm_pkg::PROD_W-1:0]         floor_rhs;
    logic [D_W-1:0]                     d_sum;
    logic [rlm_pkg::PROD_W-1:0]         rounded;
    logic [M_W-1:0]                     mag_raw;
    logic                               load_out;

    rlm_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    always_comb
    begin
        case (state_reg)
            S_FLOOR_MUL:
            begin
                mul_a = {{(rlm_pkg::MUL_W - CNT_W){1'b0}}, s_reg};
                mul_b = rlm_pkg::FIVE_POW_10;
            end
            S_SQ_MUL:
            begin
                mul_a = {{(rlm_pkg::MUL_W - rlm_pkg::Y_W){1'b0}}, y_reg};
                mul_b = {{(rlm_pkg::MUL_W - rlm_pkg::Y_W){1'b0}}, y_reg};
            end
            default:
            begin
                mul_a = d_reg;
                mul_b = rlm_pkg::DB_PER_OCT_Q20;
            end
        endcase
    end

    // Q1.30 square truncated to Q2.30; its top bit says it reached 2.0.
    assign sq_t      = prod[2*rlm_pkg::Y_W-1 -: T_W];
    assign frac_step = {frac_reg[rlm_pkg::FRAC_BITS-2:0], sq_t[rlm_pkg::Y_W]};
    assign floor_rhs = {{(rlm_pkg::PROD_W - CNT_W - rlm_pkg::FLOOR_SHIFT){1'b0}},
                        n_reg, {rlm_pkg::FLOOR_SHIFT{1'b0}}};

    // Full scale minus log2(S/N); the count's log2 still sits in e_reg and frac_reg.
    assign d_sum = {1'b0, rlm_pkg::FULL_SCALE_Q24}
                 + {{(D_W - L_W){1'b0}}, e_reg, frac_reg}
                 - {{(D_W - L_W){1'b0}}, ls_reg};

    assign rounded = prod + rlm_pkg::ROUND_Q44;
    assign mag_raw = rounded[rlm_pkg::PROD_W-1 -: M_W];

    assign load_out = (state_reg == S_DONE) && (!out_vld_reg || levels.ready);
    assign busy     = (state_reg != S_IDLE);

    assign levels.valid    = out_vld_reg;
    assign levels.level_db = out_level_reg;
    assign levels.overflow = out_ovf_reg;

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        iter_next      = iter_reg;
        s_next         = s_reg;
        n_next         = n_reg;
        ovf_next       = ovf_reg;
        x_next         = x_reg;
        e_next         = e_reg;
        y_next         = y_reg;
        frac_next      = frac_reg;
        ls_next        = ls_reg;
        d_next         = d_reg;
        mag_next       = mag_reg;
        out_vld_next   = (out_vld_reg && !levels.ready) || load_out;
        out_level_next = out_level_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (chunk_ctl.start)
                begin
                    s_next    = chunk_sum[CNT_W-1:0];
                    n_next    = chunk_count;
                    ovf_next  = chunk_ctl.overflow;
                    x_next    = NORM_W'(chunk_sum);
                    e_next    = E_W'(NORM_W - 1);
                    pass_next = 1'b0;
                    if (chunk_count == '0)
                    begin
                        mag_next   = rlm_pkg::FLOOR_MAG;
                        state_next = S_DONE;
                    end
                    else if (chunk_sum < {{(SUM_W - CNT_W){1'b0}}, chunk_count})
                    begin
                        state_next = S_FLOOR_MUL;
                    end
                    else
                    begin
                        state_next = S_NORM;
                    end
                end
            end
            S_FLOOR_MUL:
            begin
                state_next = S_FLOOR_CHK;
            end
            S_FLOOR_CHK:
            begin
                if (prod < floor_rhs)
                begin
                    mag_next   = rlm_pkg::FLOOR_MAG;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (x_reg[NORM_W-1])
                begin
                    y_next     = x_reg[NORM_W-1 -: rlm_pkg::Y_W];
                    frac_next  = '0;
                    iter_next  = '0;
                    state_next = S_SQ_MUL;
                end
                else
                begin
                    x_next = {x_reg[NORM_W-2:0], 1'b0};
                    e_next = e_reg - 1'b1;
                end
            end
            S_SQ_MUL:
            begin
                state_next = S_SQ_CHK;
            end
            S_SQ_CHK:
            begin
                frac_next = frac_step;
                y_next    = sq_t[rlm_pkg::Y_W] ? sq_t[rlm_pkg::Y_W:1]
                                               : sq_t[rlm_pkg::Y_W-1:0];
                iter_next = iter_reg + 1'b1;
                if (iter_reg == rlm_pkg::ITER_W'(rlm_pkg::FRAC_BITS - 1))
                begin
                    if (!pass_reg)
                    begin
                        ls_next    = {e_reg, frac_step};
                        x_next     = {{(NORM_W - CNT_W){1'b0}}, n_reg};
                        e_next     = E_W'(NORM_W - 1);
                        pass_next  = 1'b1;
                        state_next = S_NORM;
                    end
                    else
                    begin
                        state_next = S_DIFF;
                    end
                end
                else
                begin
                    state_next = S_SQ_MUL;
                end
            end
            S_DIFF:
            begin
                d_next     = d_sum[D_W-1] ? '0 : d_sum[rlm_pkg::MUL_W-1:0];
                state_next = S_MAG_MUL;
            end
            S_MAG_MUL:
            begin
                state_next = S_MAG_RND;
            end
            S_MAG_RND:
            begin
                mag_next   = (mag_raw > M_W'(rlm_pkg::FLOOR_MAG)) ? rlm_pkg::FLOOR_MAG
                                                               : mag_raw[rlm_pkg::MAG_W-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    out_level_next = -$signed({1'b0, mag_reg});
                    out_ovf_next   = ovf_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= 1'b0;
            iter_reg      <= '0;
            out_vld_reg   <= 1'b0;
            out_level_reg <= '0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            iter_reg      <= iter_next;
            out_vld_reg   <= out_vld_next;
            out_level_reg <= out_level_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg         <= s_next;
        n_reg         <= n_next;
        ovf_reg       <= ovf_next;
        x_reg         <= x_next;
        e_reg         <= e_next;
        y_reg         <= y_next;
        frac_reg      <= frac_next;
        ls_reg        <= ls_next;
        d_reg         <= d_next;
        mag_reg       <= mag_next;
    end

endmodule

`default_nettype wire

@@ tb/tb_rms_level_meter_db.sv @@
`timescale 1ns / 100ps

module tb_rms_level_meter_db;

    localparam int SAMPLE_W = rlm_pkg::SAMPLE_W;
    localparam int CHAN_W   = rlm_pkg::CHAN_W;
    localparam int LEVEL_W  = rlm_pkg::LEVEL_W;

    localparam int CHANNEL_COUNT = 8;
    localparam int FRAME_LIMIT  = 1024;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES = 1500;
    localparam int RANDOM_ITEMS = 210;

    localparam bit [63:0] FLOOR_DB_MAG = 64'd25600;
    localparam bit [63:0] FIVE_POW_TEN = 64'd9765625;
    localparam bit [63:0] TWO_POW_20 = 64'd1048576;
    localparam bit [63:0] DB_PER_OCTAVE = 64'd808071242;
    localparam bit [63:0] FULL_SCALE_LOG = 64'd30 << 24;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]          channel;
        logic                       eoc;
    } sample_item_t;

    typedef struct {
        logic signed [LEVEL_W-1:0] level_db;
        logic                      overflow;
    } level_result_t;

    logic clk;
    logic rst_n;

    rlm_sample_if samples_ch();
    rlm_level_if  levels_ch();
    rlm_cfg_if    cfg_ch();

    rms_level_meter_db #(
        .CHANNELS(CHANNEL_COUNT),
        .MAX_FRAMES(FRAME_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .samples(samples_ch),
        .levels(levels_ch),
        .cfg(cfg_ch)
    );

    sample_item_t  pending_items[$];
    level_result_t expected_levels[$];

    // Shadow of the meter's state.
    logic [CHAN_W-1:0] measured_channel;
    bit [63:0]         square_acc;
    bit [63:0]         frames_taken;
    bit                frames_dropped;

    bit offering;
    bit sample_taken;
    bit level_taken;
    bit idle_on;
    int send_gap;
    int recv_gap;
    int hold_left;
    int mismatch_count;
    int random_items;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Q.24 log2 of x (x >= 1): msb position, then 24 fraction bits by squaring.
    function automatic bit [63:0] log2_fix24(input bit [63:0] x);
        int unsigned msb;
        int i;
        bit [63:0] y;
        bit [63:0] frac;
        msb = 0;
        while (msb < 63 && (x >> (msb + 1)) != 0)
            msb++;
        y = (msb >= 30) ? (x >> (msb - 30)) : (x << (30 - msb));
        frac = 0;
        for (i = 0; i < 24; i++)
        begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd1 << 31))
            begin
                y = y >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(msb) << 24) | frac;
    endfunction

    // Updates shadow state, queues expected levels and checks each taken level.
    always @(posedge clk)
    begin
        level_result_t exp_lvl;
        level_result_t got;
        bit [63:0] log_sum;
        bit [63:0] log_cnt;
        bit [63:0] atten;
        bit [63:0] mag;
        int amp;
        if (samples_ch.valid && samples_ch.ready)
        begin
            sample_taken = 1'b1;
            if (samples_ch.channel == measured_channel)
            begin
                if (frames_taken >= FRAME_LIMIT)
                    frames_dropped = 1'b1;
                else
                begin
                    amp = int'(samples_ch.sample);
                    if (amp < 0)
                        amp = -amp;
                    square_acc += 64'(amp * amp);
                    frames_taken++;
                end
            end
            if (samples_ch.end_of_chunk)
            begin
                if (frames_taken == 0)
                    mag = FLOOR_DB_MAG;
                else if (square_acc < frames_taken &&
                         square_acc * FIVE_POW_TEN < frames_taken * TWO_POW_20)
                    mag = FLOOR_DB_MAG;
                else
                begin
                    log_sum = log2_fix24(square_acc);
                    log_cnt = log2_fix24(frames_taken);
                    if (log_sum >= log_cnt)
                        atten = (log_sum - log_cnt >= FULL_SCALE_LOG) ? 64'd0
                                : FULL_SCALE_LOG - (log_sum - log_cnt);
                    else
                        atten = FULL_SCALE_LOG + (log_cnt - log_sum);
                    mag = (atten * DB_PER_OCTAVE + (64'd1 << 43)) >> 44;
                    if (mag > FLOOR_DB_MAG)
                        mag = FLOOR_DB_MAG;
                end
                exp_lvl.level_db = LEVEL_W'(64'd0 - mag);
                exp_lvl.overflow = frames_dropped;
                expected_levels.push_back(exp_lvl);
                square_acc = 0;
                frames_taken = 0;
                frames_dropped = 1'b0;
            end
        end
        if (levels_ch.valid && levels_ch.ready)
        begin
            level_taken = 1'b1;
            got.level_db = levels_ch.level_db;
            got.overflow = levels_ch.overflow;
            if (expected_levels.size() == 0)
                report_mismatch($sformatf("unexpected level %0d overflow %0b",
                                          got.level_db, got.overflow));
            else
            begin
                exp_lvl = expected_levels.pop_front();
                if (got.level_db !== exp_lvl.level_db)
                    report_mismatch($sformatf("level_db got %0d want %0d",
                                              got.level_db, exp_lvl.level_db));
                if (got.overflow !== exp_lvl.overflow)
                    report_mismatch($sformatf("overflow got %0b want %0b",
                                              got.overflow, exp_lvl.overflow));
            end
        end
    end

    // Long receiver hold-off, counted down on its own.
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left--;
    end

    // Sample driver.
    always @(negedge clk)
    begin
        sample_item_t itm;
        if (sample_taken)
        begin
            offering = 1'b0;
            sample_taken = 1'b0;
            send_gap = idle_on ? $urandom_range(0, 13) : 0;
        end
        if (!offering)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (pending_items.size() > 0)
            begin
                itm = pending_items.pop_front();
                samples_ch.sample <= itm.sample;
                samples_ch.channel <= itm.channel;
                samples_ch.end_of_chunk <= itm.eoc;
                offering = 1'b1;
            end
        end
        samples_ch.valid <= offering;
    end

    // Level receiver.
    always @(negedge clk)
    begin
        if (level_taken)
        begin
            level_taken = 1'b0;
            recv_gap = idle_on ? $urandom_range(0, 13) : 0;
        end
        if (hold_left > 0)
            levels_ch.ready <= 1'b0;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            levels_ch.ready <= 1'b0;
        end
        else
            levels_ch.ready <= 1'b1;
    end

    task automatic queue_sample(input int value, input int chan, input bit eoc);
        sample_item_t itm;
        itm.sample = SAMPLE_W'(value);
        itm.channel = CHAN_W'(chan);
        itm.eoc = eoc;
        pending_items.push_back(itm);
    endtask

    // Random length and level; a lone mark on another channel is an empty chunk.
    task automatic queue_random_chunk(input int max_len);
        int len;
        int pick;
        int shift;
        int k;
        int chan;
        logic signed [SAMPLE_W-1:0] s;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            len = 0;
        else if (pick < 80)
            len = $urandom_range(1, (max_len < 16) ? max_len : 16);
        else
            len = $urandom_range(1, max_len);
        shift = $urandom_range(0, 15);
        for (k = 0; k <= len; k++)
        begin
            if (k < len)
                chan = ($urandom_range(0, 99) < 70) ? int'(measured_channel)
                       : $urandom_range(0, CHANNEL_COUNT - 1);
            else
                chan = ($urandom_range(0, 1) == 0) ? int'(measured_channel)
                       : $urandom_range(0, CHANNEL_COUNT - 1);
            pick = $urandom_range(0, 99);
            if (pick < 3)
                s = -16'sd32768;
            else if (pick < 6)
                s = 16'sd32767;
            else
                s = $signed(SAMPLE_W'($urandom)) >>> shift;
            queue_sample(int'(s), chan, k == len);
            random_items++;
        end
    endtask

    task automatic queue_random_items(input int target);
        int chunks;
        chunks = 0;
        while (random_items < target)
        begin
            if (chunks % 8 == 0)
                idle_on = $urandom_range(0, 2) != 0;
            queue_random_chunk(($urandom_range(0, 9) == 0) ? 80 : 24);
            chunks++;
            // Keep the driver queue short so idle modes follow the stream.
            while (pending_items.size() > 64)
            begin
                @(posedge clk);
                #1;
            end
        end
    endtask

    task automatic wait_until_drained();
        int k;
        while (pending_items.size() != 0 || offering || expected_levels.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
        for (k = 0; k < SETTLE_CYCLES; k++)
            @(posedge clk);
        #1;
    endtask

    task automatic write_channel_select(input logic [CHAN_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.channel_select <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        measured_channel = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        #1;
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        samples_ch.valid = 1'b0;
        samples_ch.sample = '0;
        samples_ch.channel = '0;
        samples_ch.end_of_chunk = 1'b0;
        levels_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.channel_select = '0;
        measured_channel = '0;
        square_acc = 0;
        frames_taken = 0;
        frames_dropped = 1'b0;
        offering = 1'b0;
        sample_taken = 1'b0;
        level_taken = 1'b0;
        idle_on = 1'b1;
        send_gap = 0;
        recv_gap = 0;
        hold_left = 0;
        mismatch_count = 0;
        random_items = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #1;

        write_channel_select(3'd0);

        // Empty chunk ended by a mark on another channel.
        queue_sample(0, 1, 1'b1);
        // Full scale, near full scale, silence and one LSB.
        queue_sample(-32768, 0, 1'b1);
        queue_sample(32767, 0, 1'b1);
        queue_sample(0, 0, 1'b1);
        queue_sample(1, 0, 1'b1);
        // Other channels are ignored; the mark still ends the chunk.
        queue_sample(-1, 0, 1'b0);
        queue_sample(32767, 3, 1'b0);
        queue_sample(-2, 0, 1'b0);
        queue_sample(5, 7, 1'b1);
        queue_sample(16384, 0, 1'b0);
        queue_sample(-16384, 0, 1'b0);
        queue_sample(-32768, 0, 1'b0);
        queue_sample(32767, 0, 1'b1);
        queue_sample(0, 0, 1'b0);
        queue_sample(0, 0, 1'b0);
        queue_sample(0, 0, 1'b0);
        queue_sample(1, 0, 1'b1);
        queue_sample(-32768, 2, 1'b1);
        wait_until_drained();

        // Exactly the frame limit fits; the next matching sample is dropped.
        idle_on = 1'b0;
        for (k = 0; k < FRAME_LIMIT; k++)
            queue_sample(int'($signed(SAMPLE_W'($urandom))), 0, 1'b0);
        queue_sample(-32768, 0, 1'b1);
        // The flag must not carry into the next chunk.
        queue_sample(0, 5, 1'b1);
        wait_until_drained();

        write_channel_select(3'd7);
        queue_random_items(RANDOM_ITEMS / 3);
        wait_until_drained();

        // Receiver stalls while short chunks keep coming, so the input backs up.
        write_channel_select(CHAN_W'($urandom_range(1, 6)));
        idle_on = 1'b0;
        hold_left = HOLD_CYCLES;
        for (k = 0; k < 20; k++)
            queue_random_chunk(3);
        queue_random_items(2 * RANDOM_ITEMS / 3);
        wait_until_drained();

        write_channel_select(3'd0);
        queue_random_items(RANDOM_ITEMS);
        wait_until_drained();

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("TIMEOUT at %0t ns", $time);
        $display("Test completed with failures");
        $finish;
    end

endmodule
